// File: rtl/core/tks_pkg.sv
// Package for the typed keyword spotter: payload structs, operation codes,
// sequencer states and the case-folding helper. No dependencies.
package tks_pkg;

  localparam logic [2:0] OP_CHAR      = 3'd0;
  localparam logic [2:0] OP_BACKSPACE = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_PAT_BYTE  = 3'd3;
  localparam logic [2:0] OP_PAT_LEN   = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] key_char;
    logic [3:0] pattern_slot;
    logic [4:0] pattern_pos;
  } in_item_t;

  typedef struct packed {
    logic       match_found;
    logic [3:0] matched_slot;
    logic [5:0] fill_level;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TRIM,
    S_APPEND,
    S_SLOT,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/typed_keyword_spotter.sv
// Top level of the typed keyword spotter: history ring, pattern store and
// the sequencer that checks one pattern byte at a time. Uses tks_pkg.
//
// Usage: items enter on in_valid/in_ready as tks_pkg::in_item_t, results
// leave on out_valid/out_ready as tks_pkg::out_item_t, one result for every
// item. The cfg_count register is written through cfg_we/cfg_data; the user
// must write it only while the block is idle; the block does not enforce that.
// Editing items and pattern writes pass through the decode state to the
// done state. A typed character passes through decode, trim and append,
// then visits the slots in turn and, for each pattern byte compared, a
// fetch and a check state, since the single byte comparator reads the
// history ring and the pattern memory once per compare. The history is
// a ring buffer, so trimming it only moves its base pointer. in_ready is
// high only while the sequencer is idle.
// A finished result sits in the output register; the next item is taken
// while it waits, and the sequencer holds its result until the output
// register frees up when the receiver stalls.
// Reset clears the history length and base, the pattern lengths and cfg_count.
// Pattern bytes and history contents are undefined until written.
module typed_keyword_spotter #(
  parameter int HISTORY_DEPTH = 64,
  parameter int PATTERN_MAX   = 30,
  parameter int PATTERN_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  tks_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tks_pkg::out_item_t out_data
);

  localparam int SLOT_BYTES = PATTERN_MAX - 1;
  localparam int HADDR_W    = $clog2(HISTORY_DEPTH);
  localparam int PL_W       = $clog2(SLOT_BYTES + 1);
  localparam int SIDX_W     = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int SCNT_W     = $clog2(PATTERN_SLOTS + 1);
  localparam int PDEPTH     = PATTERN_SLOTS * SLOT_BYTES;
  localparam int PADDR_W    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int SBASE_W    = $clog2(PDEPTH + 1);

  tks_pkg::state_t   state, state_next;
  tks_pkg::in_item_t item;
  logic [4:0]         cfg_count;
  logic [HADDR_W-1:0] hist_len, hist_len_next;
  logic [HADDR_W-1:0] hist_base, hist_base_next;
  logic [SCNT_W-1:0]  slot, slot_next;
  logic [SBASE_W-1:0] slot_base, slot_base_next;
  logic [PADDR_W-1:0] pat_ptr, pat_ptr_next;
  logic [HADDR_W-1:0] off, off_next;
  logic [PL_W-1:0]    rem, rem_next;
  logic               found, found_next;
  logic [PL_W-1:0]    pat_len [PATTERN_SLOTS];
  logic [7:0]         hist_mem [HISTORY_DEPTH];
  logic [7:0]         pat_mem [PDEPTH];
  logic [7:0]         hist_rd, pat_rd;
  logic               load_out;
  logic [PL_W-1:0]    cur_len;
  logic [HADDR_W-1:0] keep;
  logic               wr_slot_ok, wr_pos_ok;
  logic [SIDX_W-1:0]  wr_slot;
  logic [PADDR_W-1:0] pat_waddr;
  logic [HADDR_W-1:0] hist_waddr, hist_raddr;
  logic [PL_W-1:0]    len_wdata;

  function automatic logic [HADDR_W-1:0] ring_add(input logic [HADDR_W-1:0] a,
                                                  input logic [HADDR_W-1:0] b);
    logic [HADDR_W:0] s;
    s = (HADDR_W+1)'(a) + (HADDR_W+1)'(b);
    if (s >= (HADDR_W+1)'(HISTORY_DEPTH)) begin
      s = s - (HADDR_W+1)'(HISTORY_DEPTH);
    end
    return s[HADDR_W-1:0];
  endfunction

  assign in_ready   = (state == tks_pkg::S_IDLE);
  assign load_out   = (state == tks_pkg::S_DONE) && (!out_valid || out_ready);
  assign cur_len    = pat_len[SIDX_W'(slot)];
  assign wr_slot    = SIDX_W'(item.pattern_slot);
  assign wr_slot_ok = (32'(item.pattern_slot) < PATTERN_SLOTS);
  assign wr_pos_ok  = (32'(item.pattern_pos) < SLOT_BYTES);
  assign pat_waddr  = PADDR_W'(32'(wr_slot) * SLOT_BYTES + 32'(item.pattern_pos));
  assign hist_waddr = ring_add(hist_base, hist_len);
  assign hist_raddr = ring_add(hist_base, off);
  assign keep       = (32'(hist_len) > PATTERN_MAX + 1) ? HADDR_W'(PATTERN_MAX + 1)
                                                        : hist_len;
  assign len_wdata  = (32'(item.key_char) > SLOT_BYTES) ? PL_W'(SLOT_BYTES)
                                                        : PL_W'(item.key_char);

  always_comb begin
    state_next     = state;
    hist_len_next  = hist_len;
    hist_base_next = hist_base;
    slot_next      = slot;
    slot_base_next = slot_base;
    pat_ptr_next   = pat_ptr;
    off_next       = off;
    rem_next       = rem;
    found_next     = found;
    case (state)
      tks_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tks_pkg::S_DECODE;
        end
      end
      tks_pkg::S_DECODE: begin
        found_next = 1'b0;
        slot_next  = '0;
        state_next = tks_pkg::S_DONE;
        case (item.operation)
          tks_pkg::OP_CHAR:      state_next = tks_pkg::S_TRIM;
          tks_pkg::OP_BACKSPACE: begin
            if (hist_len != '0) begin
              hist_len_next = hist_len - 1'b1;
            end
          end
          tks_pkg::OP_CLEAR:     hist_len_next = '0;
          default: ;
        endcase
      end
      tks_pkg::S_TRIM: begin
        if (32'(hist_len) >= HISTORY_DEPTH - 2) begin
          hist_base_next = ring_add(hist_base, hist_len - keep);
          hist_len_next  = keep;
        end
        state_next = tks_pkg::S_APPEND;
      end
      tks_pkg::S_APPEND: begin
        hist_len_next  = hist_len + 1'b1;
        slot_next      = '0;
        slot_base_next = '0;
        state_next     = tks_pkg::S_SLOT;
      end
      tks_pkg::S_SLOT: begin
        if (32'(slot) >= PATTERN_SLOTS || 32'(slot) >= 32'(cfg_count)) begin
          state_next = tks_pkg::S_DONE;
        end else if (cur_len == '0 || 32'(cur_len) > 32'(hist_len)) begin
          slot_next      = slot + 1'b1;
          slot_base_next = slot_base + SBASE_W'(SLOT_BYTES);
        end else begin
          off_next     = hist_len - HADDR_W'(cur_len);
          pat_ptr_next = PADDR_W'(slot_base);
          rem_next     = cur_len;
          state_next   = tks_pkg::S_FETCH;
        end
      end
      tks_pkg::S_FETCH: begin
        state_next = tks_pkg::S_CHECK;
      end
      tks_pkg::S_CHECK: begin
        if (hist_rd != pat_rd) begin
          slot_next      = slot + 1'b1;
          slot_base_next = slot_base + SBASE_W'(SLOT_BYTES);
          state_next     = tks_pkg::S_SLOT;
        end else if (rem == PL_W'(1)) begin
          found_next    = 1'b1;
          hist_len_next = '0;
          state_next    = tks_pkg::S_DONE;
        end else begin
          rem_next     = rem - 1'b1;
          off_next     = off + 1'b1;
          pat_ptr_next = pat_ptr + 1'b1;
          state_next   = tks_pkg::S_FETCH;
        end
      end
      tks_pkg::S_DONE: begin
        if (load_out) begin
          state_next = tks_pkg::S_IDLE;
        end
      end
      default: state_next = tks_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tks_pkg::S_IDLE;
      hist_len  <= '0;
      hist_base <= '0;
      cfg_count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PATTERN_SLOTS; i++) begin
        pat_len[i] <= '0;
      end
    end else begin
      state     <= state_next;
      hist_len  <= hist_len_next;
      hist_base <= hist_base_next;
      if (cfg_we) begin
        cfg_count <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == tks_pkg::S_DECODE && item.operation == tks_pkg::OP_PAT_LEN &&
          wr_slot_ok) begin
        pat_len[wr_slot] <= len_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    slot      <= slot_next;
    slot_base <= slot_base_next;
    pat_ptr   <= pat_ptr_next;
    off       <= off_next;
    rem       <= rem_next;
    found     <= found_next;
    if (load_out) begin
      out_data.match_found  <= found;
      out_data.matched_slot <= found ? 4'(slot) : 4'd0;
      out_data.fill_level   <= 6'(hist_len);
    end
  end

  always_ff @(posedge clk) begin
    if (state == tks_pkg::S_APPEND) begin
      hist_mem[hist_waddr] <= tks_pkg::fold_case(item.key_char);
    end
    if (state == tks_pkg::S_FETCH) begin
      hist_rd <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == tks_pkg::S_DECODE && item.operation == tks_pkg::OP_PAT_BYTE &&
        wr_slot_ok && wr_pos_ok) begin
      pat_mem[pat_waddr] <= item.key_char;
    end
    if (state == tks_pkg::S_FETCH) begin
      pat_rd <= pat_mem[pat_ptr];
    end
  end

endmodule
